// ----- rtl/ihex_pkg.sv -----
// Shared types and constants for the Intel HEX image parser.
// Used by ihex_parse, ihex_out_reg and intel_hex_image_parser; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ihex_pkg;

   localparam int unsigned PAGE_COUNT_W = 23;
   localparam int unsigned POS_W        = 10;
   localparam int unsigned BIDX_W       = POS_W - 1;

   localparam logic [7:0]  ASCII_COLON  = 8'h3A;

   localparam logic [7:0]  REC_DATA     = 8'h00;
   localparam logic [7:0]  REC_EOF      = 8'h01;
   localparam logic [7:0]  REC_EXT_LIN  = 8'h04;

   localparam logic        KIND_DATA    = 1'b0;
   localparam logic        KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic                    kind;
      logic [7:0]              data_byte;
      logic [31:0]             byte_offset;
      logic [31:0]             byte_total;
      logic [31:0]             start_address;
      logic [31:0]             data_records;
      logic [PAGE_COUNT_W-1:0] page_count;
   } rsp_type;

   // bit 4 flags a valid hex digit, bits 3..0 hold its value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      d = 5'd0;
      case (c) inside
         [8'h30:8'h39]: d = {1'b1, c[3:0]};
         [8'h41:8'h46],
         [8'h61:8'h66]: d = {1'b1, c[3:0] + 4'd9};
         default:       d = 5'd0;
      endcase
      return d;
   endfunction

   function automatic logic [31:0] sat_inc(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ihex_parse.sv -----
// Record parser state and per-character update for the Intel HEX image parser.
// Depends on ihex_pkg for types, codes and the hex digit decoder.
`timescale 1ns / 1ps
`default_nettype none

module ihex_parse #(
   parameter int unsigned PAGE_BYTES = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       char_in,
   input  wire logic             new_file,
   output      logic             res_valid,
   output      ihex_pkg::rsp_type res
);

   localparam int unsigned REM_W = $clog2(PAGE_BYTES);
   localparam logic [REM_W-1:0] REM_LAST = REM_W'(PAGE_BYTES - 1);

   logic [ihex_pkg::POS_W-1:0]        pos_ff, pos_in, pos_cur, idx;
   logic [4:0]                        hn_ff, hn_in, hn_cur, lo;
   logic [7:0]                        len_ff, len_in, len_cur;
   logic [7:0]                        type_ff, type_in, type_cur;
   logic [15:0]                       addr_ff, addr_in, addr_cur;
   logic [15:0]                       ftd_ff, ftd_in, ftd_cur;
   logic [31:0]                       rc_ff, rc_in, rc_cur;
   logic [31:0]                       sb_ff, sb_in, sb_cur;
   logic [31:0]                       drc_ff, drc_in, drc_cur;
   logic [31:0]                       base_ff, base_in, base_cur;
   logic [REM_W-1:0]                  rem_ff, rem_in, rem_cur;
   logic [ihex_pkg::PAGE_COUNT_W-1:0] pages_ff, pages_in, pages_cur;
   logic [ihex_pkg::BIDX_W-1:0]       bidx, data_end, didx;
   logic [7:0]                        byte_val;

   always_comb begin
      pos_cur   = new_file ? '0 : pos_ff;
      hn_cur    = new_file ? '0 : hn_ff;
      len_cur   = new_file ? '0 : len_ff;
      type_cur  = new_file ? '0 : type_ff;
      addr_cur  = new_file ? '0 : addr_ff;
      ftd_cur   = new_file ? '0 : ftd_ff;
      rc_cur    = new_file ? '0 : rc_ff;
      sb_cur    = new_file ? '0 : sb_ff;
      drc_cur   = new_file ? '0 : drc_ff;
      base_cur  = new_file ? '0 : base_ff;
      rem_cur   = new_file ? '0 : rem_ff;
      pages_cur = new_file ? '0 : pages_ff;

      pos_in   = pos_cur;
      hn_in    = hn_cur;
      len_in   = len_cur;
      type_in  = type_cur;
      addr_in  = addr_cur;
      ftd_in   = ftd_cur;
      rc_in    = rc_cur;
      sb_in    = sb_cur;
      drc_in   = drc_cur;
      base_in  = base_cur;
      rem_in   = rem_cur;
      pages_in = pages_cur;

      res_valid = 1'b0;
      res       = '0;

      idx      = pos_cur - ihex_pkg::POS_W'(1);
      bidx     = idx[ihex_pkg::POS_W-1:1];
      data_end = {1'b0, len_cur} + ihex_pkg::BIDX_W'(4);
      didx     = bidx - ihex_pkg::BIDX_W'(4);
      lo       = ihex_pkg::hex_digit(char_in);
      byte_val = (hn_cur[4] && lo[4]) ? {hn_cur[3:0], lo[3:0]} : 8'd0;

      if (pos_cur == '0) begin
         if (char_in == ihex_pkg::ASCII_COLON) begin
            pos_in = ihex_pkg::POS_W'(1);
            rc_in  = ihex_pkg::sat_inc(rc_cur);
         end
      end else begin
         pos_in = pos_cur + ihex_pkg::POS_W'(1);
         if (!idx[0]) begin
            hn_in = lo;
         end else if (bidx == ihex_pkg::BIDX_W'(0)) begin
            len_in = byte_val;
         end else if (bidx == ihex_pkg::BIDX_W'(1)) begin
            addr_in = {byte_val, addr_cur[7:0]};
         end else if (bidx == ihex_pkg::BIDX_W'(2)) begin
            addr_in = {addr_cur[15:8], byte_val};
         end else if (bidx == ihex_pkg::BIDX_W'(3)) begin
            type_in = byte_val;
         end else if (bidx < data_end) begin
            if (didx == ihex_pkg::BIDX_W'(0)) begin
               ftd_in = {byte_val, ftd_cur[7:0]};
            end else if (didx == ihex_pkg::BIDX_W'(1)) begin
               ftd_in = {ftd_cur[15:8], byte_val};
            end
            if (type_cur == ihex_pkg::REC_DATA) begin
               res_valid       = 1'b1;
               res.kind        = ihex_pkg::KIND_DATA;
               res.data_byte   = byte_val;
               res.byte_offset = sb_cur;
               if (sb_cur != 32'hFFFF_FFFF) begin
                  sb_in = sb_cur + 32'd1;
                  if (rem_cur == '0) begin
                     pages_in = pages_cur + ihex_pkg::PAGE_COUNT_W'(1);
                  end
                  rem_in = (rem_cur == REM_LAST) ? '0 : rem_cur + REM_W'(1);
               end
            end
         end else begin
            pos_in = '0;
            if (type_cur == ihex_pkg::REC_DATA) begin
               drc_in = ihex_pkg::sat_inc(drc_cur);
               if (rc_cur == 32'd2) begin
                  base_in = base_cur + {16'd0, addr_cur};
               end
            end else if (type_cur == ihex_pkg::REC_EOF) begin
               res_valid         = 1'b1;
               res.kind          = ihex_pkg::KIND_SUMMARY;
               res.byte_total    = sb_cur;
               res.start_address = base_cur;
               res.data_records  = drc_cur;
               res.page_count    = pages_cur;
            end else if (type_cur == ihex_pkg::REC_EXT_LIN) begin
               if (rc_cur == 32'd1 && len_cur == 8'd2) begin
                  base_in = {ftd_cur, 16'd0};
               end
            end
         end
      end

      if (!step) begin
         res_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         hn_ff    <= '0;
         len_ff   <= '0;
         type_ff  <= '0;
         addr_ff  <= '0;
         ftd_ff   <= '0;
         rc_ff    <= '0;
         sb_ff    <= '0;
         drc_ff   <= '0;
         base_ff  <= '0;
         rem_ff   <= '0;
         pages_ff <= '0;
      end else if (step) begin
         pos_ff   <= pos_in;
         hn_ff    <= hn_in;
         len_ff   <= len_in;
         type_ff  <= type_in;
         addr_ff  <= addr_in;
         ftd_ff   <= ftd_in;
         rc_ff    <= rc_in;
         sb_ff    <= sb_in;
         drc_ff   <= drc_in;
         base_ff  <= base_in;
         rem_ff   <= rem_in;
         pages_ff <= pages_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ihex_out_reg.sv -----
// Result register for the Intel HEX image parser: holds one word until taken.
// Depends on ihex_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module ihex_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire ihex_pkg::rsp_type res,
   input  wire logic              rsp_stall,
   output      logic              rsp_valid,
   output      ihex_pkg::rsp_type rsp
);

   logic              valid_ff;
   ihex_pkg::rsp_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= res;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

`default_nettype wire

// ----- rtl/intel_hex_image_parser.sv -----
// Top level of the Intel HEX image parser: input register, parser, result register.
// Depends on ihex_pkg, ihex_parse and ihex_out_reg.
//
// Takes one ASCII character per word and walks Intel HEX records. Each data
// byte of a type-0 record comes out as a data word with its offset in the
// image; the end-of-file record produces one summary word with byte total,
// start address, data record count and page count. Asserting req_new_file
// clears all parser state before that character is used. Each character
// is held in the input register, the parser updates all record state on
// the step that consumes it, and any result lands in the output register,
// which drives rsp_valid. Throughput is one character per clock unless
// rsp_stall holds a result.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_image_parser #(
   parameter int unsigned PAGE_BYTES = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic [7:0]                        req_char_in,
   input  wire logic                              req_new_file,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic                              rsp_kind,
   output      logic [7:0]                        rsp_data_byte,
   output      logic [31:0]                       rsp_byte_offset,
   output      logic [31:0]                       rsp_byte_total,
   output      logic [31:0]                       rsp_start_address,
   output      logic [31:0]                       rsp_data_records,
   output      logic [ihex_pkg::PAGE_COUNT_W-1:0] rsp_page_count
);

   logic              in_valid_ff;
   logic [7:0]        char_ff;
   logic              new_file_ff;
   logic              slot_free;
   logic              step;
   logic              res_valid;
   ihex_pkg::rsp_type res;
   ihex_pkg::rsp_type rsp;

   assign slot_free = !rsp_valid || !rsp_stall;
   assign step      = in_valid_ff && slot_free;
   assign req_stall = in_valid_ff && !slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         char_ff     <= req_char_in;
         new_file_ff <= req_new_file;
      end
   end

   ihex_parse #(
      .PAGE_BYTES(PAGE_BYTES)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .char_in  (char_ff),
      .new_file (new_file_ff),
      .res_valid(res_valid),
      .res      (res)
   );

   ihex_out_reg u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (res_valid),
      .res      (res),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp      (rsp)
   );

   assign rsp_kind          = rsp.kind;
   assign rsp_data_byte     = rsp.data_byte;
   assign rsp_byte_offset   = rsp.byte_offset;
   assign rsp_byte_total    = rsp.byte_total;
   assign rsp_start_address = rsp.start_address;
   assign rsp_data_records  = rsp.data_records;
   assign rsp_page_count    = rsp.page_count;

endmodule

`default_nettype wire
